// ===== hdl/back_forward_history_unit_macros.svh =====
// Assertion helpers for the block that checks itself.
`ifndef BACK_FORWARD_HISTORY_UNIT_MACROS_SVH
`define BACK_FORWARD_HISTORY_UNIT_MACROS_SVH

// Implication or plain property, sampled on clk_i, off while in reset.
`define BFH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property that must also hold while reset is applied.
`define BFH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/bfh_pkg.sv =====
`default_nettype none

package bfh_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned NODE_W = 32;
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned LVL_W  = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [NODE_W-1:0] NO_NODE = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_VISIT   = 2'd0,
    ACT_BACK    = 2'd1,
    ACT_FORWARD = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_VISIT,
    OP_BACK,
    OP_FWD,
    OP_CLEAR
  } op_e;

  // datapath -> controller
  typedef struct packed {
    logic page_valid;
    logic cur_match;
    logic back_empty;
    logic back_full;
    logic fwd_empty;
    logic fwd_full;
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // request accepted: latch node id, read both stack tops
    logic apply;    // commit op and load the result register
    op_e  op;
    logic ok;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/bfh_req_if.sv =====
`default_nettype none

interface bfh_req_if;
  import bfh_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ACT_W-1:0]     action;
  logic [NODE_W-1:0]    node_id;

  modport source (output valid, output action, output node_id, input ready);
  modport sink   (input valid, input action, input node_id, output ready);
endinterface

`default_nettype wire

// ===== hdl/bfh_rsp_if.sv =====
`default_nettype none

interface bfh_rsp_if;
  import bfh_pkg::*;

  logic              valid;
  logic              ready;
  logic              ok;
  logic [NODE_W-1:0] node;
  logic              can_back;
  logic              can_forward;
  logic              has_page;

  modport source (output valid, output ok, output node, output can_back,
                  output can_forward, output has_page, input ready);
  modport sink   (input valid, input ok, input node, input can_back,
                  input can_forward, input has_page, output ready);
endinterface

`default_nettype wire

// ===== hdl/bfh_datapath.sv =====
`default_nettype none

module bfh_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire bfh_pkg::cmd_t             cmd_i,
  input  wire logic [bfh_pkg::NODE_W-1:0] node_id_i,
  output bfh_pkg::status_t               status_o,
  output logic                           ok_o,
  output logic [bfh_pkg::NODE_W-1:0]     node_o,
  output logic                           can_back_o,
  output logic                           can_forward_o,
  output logic                           has_page_o
);
  import bfh_pkg::*;

  logic [NODE_W-1:0] back_mem [DEPTH];
  logic [NODE_W-1:0] fwd_mem  [DEPTH];

  logic [NODE_W-1:0] cur_q, cur_d;
  logic              valid_q, valid_d;
  logic [LVL_W-1:0]  back_lvl_q, back_lvl_d;
  logic [LVL_W-1:0]  fwd_lvl_q, fwd_lvl_d;
  logic [NODE_W-1:0] node_q;
  logic [NODE_W-1:0] back_rd_q, fwd_rd_q;
  logic [LVL_W-1:0]  back_top, fwd_top;
  logic              wr_back, wr_fwd;

  logic              res_ok_q;
  logic [NODE_W-1:0] res_node_q;
  logic              res_back_q, res_fwd_q, res_page_q;

  assign back_top = back_lvl_q - LVL_W'(1);
  assign fwd_top  = fwd_lvl_q - LVL_W'(1);

  assign status_o.page_valid = valid_q;
  assign status_o.cur_match  = valid_q && (cur_q == node_q);
  assign status_o.back_empty = (back_lvl_q == '0);
  assign status_o.back_full  = (back_lvl_q == LVL_W'(DEPTH));
  assign status_o.fwd_empty  = (fwd_lvl_q == '0);
  assign status_o.fwd_full   = (fwd_lvl_q == LVL_W'(DEPTH));

  assign wr_back = ((cmd_i.op == OP_VISIT) && valid_q) || (cmd_i.op == OP_FWD);
  assign wr_fwd  = (cmd_i.op == OP_BACK);

  always_comb begin
    cur_d      = cur_q;
    valid_d    = valid_q;
    back_lvl_d = back_lvl_q;
    fwd_lvl_d  = fwd_lvl_q;
    unique case (cmd_i.op)
      OP_VISIT: begin
        if (valid_q) begin
          back_lvl_d = back_lvl_q + LVL_W'(1);
        end
        fwd_lvl_d = '0;
        cur_d     = node_q;
        valid_d   = 1'b1;
      end
      OP_BACK: begin
        fwd_lvl_d  = fwd_lvl_q + LVL_W'(1);
        back_lvl_d = back_top;
        cur_d      = back_rd_q;
      end
      OP_FWD: begin
        back_lvl_d = back_lvl_q + LVL_W'(1);
        fwd_lvl_d  = fwd_top;
        cur_d      = fwd_rd_q;
      end
      OP_CLEAR: begin
        back_lvl_d = '0;
        fwd_lvl_d  = '0;
        cur_d      = NO_NODE;
        valid_d    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= NO_NODE;
      valid_q    <= 1'b0;
      back_lvl_q <= '0;
      fwd_lvl_q  <= '0;
    end else if (cmd_i.apply) begin
      cur_q      <= cur_d;
      valid_q    <= valid_d;
      back_lvl_q <= back_lvl_d;
      fwd_lvl_q  <= fwd_lvl_d;
    end
  end

  // levels only change on apply, so the tops read at capture stay current
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      node_q    <= node_id_i;
      back_rd_q <= back_mem[back_top[ADDR_W-1:0]];
      fwd_rd_q  <= fwd_mem[fwd_top[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && wr_back) begin
      back_mem[back_lvl_q[ADDR_W-1:0]] <= cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && wr_fwd) begin
      fwd_mem[fwd_lvl_q[ADDR_W-1:0]] <= cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      res_ok_q   <= cmd_i.ok;
      res_node_q <= cur_d;
      res_back_q <= (back_lvl_d != '0);
      res_fwd_q  <= (fwd_lvl_d != '0);
      res_page_q <= valid_d;
    end
  end

  assign ok_o          = res_ok_q;
  assign node_o        = res_node_q;
  assign can_back_o    = res_back_q;
  assign can_forward_o = res_fwd_q;
  assign has_page_o    = res_page_q;

endmodule

`default_nettype wire

// ===== hdl/bfh_ctrl.sv =====
`default_nettype none

module bfh_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      req_valid_i,
  input  wire logic [bfh_pkg::ACT_W-1:0] req_action_i,
  output logic                           req_ready_o,
  output logic                           rsp_valid_o,
  input  wire logic                      rsp_ready_i,
  input  wire bfh_pkg::status_t          status_i,
  output bfh_pkg::cmd_t                  cmd_o
);
  import bfh_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e  state_q;
  action_e act_q;
  logic    out_valid_q;
  logic    accept;
  logic    slot_free;
  op_e     op;
  logic    ok;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign slot_free   = !out_valid_q || rsp_ready_i;
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    op = OP_NONE;
    ok = 1'b0;
    unique case (act_q)
      ACT_VISIT: begin
        if (status_i.cur_match) begin
          ok = 1'b1;
        end else if (!(status_i.page_valid && status_i.back_full)) begin
          op = OP_VISIT;
          ok = 1'b1;
        end
      end
      ACT_BACK: begin
        if (status_i.page_valid && !status_i.back_empty && !status_i.fwd_full) begin
          op = OP_BACK;
          ok = 1'b1;
        end
      end
      ACT_FORWARD: begin
        if (status_i.page_valid && !status_i.fwd_empty && !status_i.back_full) begin
          op = OP_FWD;
          ok = 1'b1;
        end
      end
      ACT_CLEAR: begin
        op = OP_CLEAR;
        ok = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd_o.capture = accept;
    cmd_o.apply   = (state_q == ST_EXEC) && slot_free;
    cmd_o.op      = cmd_o.apply ? op : OP_NONE;
    cmd_o.ok      = ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      act_q       <= ACT_VISIT;
      out_valid_q <= 1'b0;
    end else begin
      // a new response replaces the one taken in the same cycle
      if (cmd_o.apply) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            act_q   <= action_e'(req_action_i);
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/back_forward_history_unit.sv =====
// Browser-style back/forward history: a current node plus a back and a forward
// stack of DEPTH entries each. Every request (visit, back, forward, clear)
// yields exactly one response carrying ok and the state after the step. A
// request runs in two steps: the accept edge reads both stack tops from their
// memories, then the commit edge commits the update, writes at most one stack
// entry and loads the response register. A request is accepted while a response
// is still waiting; the commit stalls only while that response is not taken.
// No clearing pass after reset: stack entries are only used below their level.
`default_nettype none
`include "back_forward_history_unit_macros.svh"

module back_forward_history_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bfh_req_if.sink   req_i,
  bfh_rsp_if.source rsp_o
);
  import bfh_pkg::*;

  status_t status;
  cmd_t    cmd;

  bfh_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_action_i (req_i.action),
    .req_ready_o  (req_i.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  bfh_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .node_id_i     (req_i.node_id),
    .status_o      (status),
    .ok_o          (rsp_o.ok),
    .node_o        (rsp_o.node),
    .can_back_o    (rsp_o.can_back),
    .can_forward_o (rsp_o.can_forward),
    .has_page_o    (rsp_o.has_page)
  );

  `BFH_ASSERT(a_one_in_flight, (req_i.valid && req_i.ready) |=> !req_i.ready, "request accepted while busy")
  `BFH_ASSERT(a_no_page_node, (rsp_o.valid && !rsp_o.has_page) |-> (rsp_o.node == NO_NODE), "no page but node not all ones")
  `BFH_ASSERT(a_stack_needs_page, (rsp_o.valid && (rsp_o.can_back || rsp_o.can_forward)) |-> rsp_o.has_page, "history entries without a current page")
  `BFH_ASSERT_ALWAYS(a_apply_in_exec, cmd.apply |-> !req_i.ready, "commit while idle")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfh_pkg::*;

  typedef struct {
    logic              ok;
    logic [NODE_W-1:0] node;
    logic              can_back;
    logic              can_fwd;
    logic              has_page;
  } nav_view_t;

  logic clk_i;
  logic rst_ni;

  bfh_req_if req_bus ();
  bfh_rsp_if rsp_bus ();

  back_forward_history_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // history as the block should see it
  logic [NODE_W-1:0] back_hist [DEPTH];
  logic [NODE_W-1:0] fwd_hist  [DEPTH];
  int unsigned       back_cnt;
  int unsigned       fwd_cnt;
  logic [NODE_W-1:0] cur_node;
  logic              cur_live;

  nav_view_t pending_views[$];
  int        mismatch_cnt;
  int        sent_cnt;
  bit        req_steady;
  bit        rsp_steady;
  int        stall_request;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #3ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Apply one request to the history and return the view it leaves.
  function automatic nav_view_t navigate(action_e act, logic [NODE_W-1:0] id);
    nav_view_t   v;
    logic        ok;
    bit          going_back;
    int unsigned src_cnt;
    int unsigned dst_cnt;
    ok = 1'b0;
    case (act)
      ACT_VISIT: begin
        if (cur_live && cur_node == id) begin
          ok = 1'b1;
        end else if (cur_live && back_cnt >= DEPTH) begin
          ok = 1'b0;
        end else begin
          if (cur_live) begin
            back_hist[back_cnt] = cur_node;
            back_cnt++;
          end
          fwd_cnt  = 0;
          cur_node = id;
          cur_live = 1'b1;
          ok       = 1'b1;
        end
      end
      ACT_BACK, ACT_FORWARD: begin
        going_back = (act == ACT_BACK);
        src_cnt    = going_back ? back_cnt : fwd_cnt;
        dst_cnt    = going_back ? fwd_cnt : back_cnt;
        if (cur_live && src_cnt != 0 && dst_cnt < DEPTH) begin
          if (going_back) begin
            fwd_hist[fwd_cnt] = cur_node;
            fwd_cnt++;
            back_cnt--;
            cur_node = back_hist[back_cnt];
          end else begin
            back_hist[back_cnt] = cur_node;
            back_cnt++;
            fwd_cnt--;
            cur_node = fwd_hist[fwd_cnt];
          end
          ok = 1'b1;
        end
      end
      default: begin
        back_cnt = 0;
        fwd_cnt  = 0;
        cur_node = NO_NODE;
        cur_live = 1'b0;
        ok       = 1'b1;
      end
    endcase
    v.ok       = ok;
    v.node     = cur_node;
    v.can_back = (back_cnt != 0);
    v.can_fwd  = (fwd_cnt != 0);
    v.has_page = cur_live;
    return v;
  endfunction

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic action_e pick_action(int w_visit, int w_back, int w_fwd);
    int r;
    r = $urandom_range(0, 99);
    if (r < w_visit) return ACT_VISIT;
    if (r < w_visit + w_back) return ACT_BACK;
    if (r < w_visit + w_back + w_fwd) return ACT_FORWARD;
    return ACT_CLEAR;
  endfunction

  function automatic logic [NODE_W-1:0] pick_node();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return cur_node;
    if (r < 25) return NO_NODE;
    if (r < 35) return $urandom_range(0, 7);
    return $urandom();
  endfunction

  // Offer one request; returns in the step of the accepting edge with valid
  // still high, so a back-to-back request needs no extra drive of valid.
  task automatic send_request(action_e act, logic [NODE_W-1:0] id);
    int gap;
    gap = pick_gap(req_steady);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid   <= 1'b1;
    req_bus.action  <= act;
    req_bus.node_id <= id;
    do @(posedge clk_i); while (!req_bus.ready);
    pending_views.push_back(navigate(act, id));
    sent_cnt++;
  endtask

  task automatic stop_requests();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic compare_field(string name, logic [NODE_W-1:0] exp_v,
                               logic [NODE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  // response ready: mostly high, short drops, now and then a long hold
  initial begin : rsp_ready_drive
    int r;
    int stall_left;
    stall_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left--;
      end else if (stall_request > 0) begin
        stall_left    = stall_request - 1;
        stall_request = 0;
        rsp_bus.ready <= 1'b0;
      end else if (rsp_steady) begin
        rsp_bus.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 199);
        if (r < 2) stall_left = $urandom_range(10, 40);
        rsp_bus.ready <= (r >= 40);
      end
    end
  end

  initial begin : rsp_check
    nav_view_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
        if (pending_views.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected response, expected none, got node %h ok %b",
                   $time, rsp_bus.node, rsp_bus.ok);
        end else begin
          want = pending_views.pop_front();
          compare_field("ok", NODE_W'(want.ok), NODE_W'(rsp_bus.ok));
          compare_field("node", want.node, rsp_bus.node);
          compare_field("can_back", NODE_W'(want.can_back), NODE_W'(rsp_bus.can_back));
          compare_field("can_forward", NODE_W'(want.can_fwd),
                        NODE_W'(rsp_bus.can_forward));
          compare_field("has_page", NODE_W'(want.has_page), NODE_W'(rsp_bus.has_page));
        end
      end
    end
  end

  task automatic test_directed_basics();
    send_request(ACT_BACK, 32'h0);            // no page yet
    send_request(ACT_FORWARD, 32'h0);
    send_request(ACT_VISIT, NO_NODE);         // all-ones id is a real node
    send_request(ACT_VISIT, NO_NODE);         // same node again: no change
    send_request(ACT_BACK, 32'hFFFF_FFFF);
    send_request(ACT_VISIT, 32'h0);
    send_request(ACT_VISIT, 32'h8000_0000);
    send_request(ACT_VISIT, 32'h7FFF_FFFF);
    send_request(ACT_BACK, 32'hDEAD_BEEF);    // id ignored
    send_request(ACT_BACK, 32'h0);
    send_request(ACT_FORWARD, 32'h1234_5678);
    send_request(ACT_FORWARD, 32'h0);
    send_request(ACT_FORWARD, 32'h0);         // forward stack now empty
    send_request(ACT_BACK, 32'h0);
    send_request(ACT_VISIT, 32'h5555_AAAA);   // drops forward history
    send_request(ACT_FORWARD, 32'h0);
    send_request(ACT_CLEAR, 32'h0);
    send_request(ACT_BACK, 32'h0);
    send_request(ACT_CLEAR, NO_NODE);
    send_request(ACT_VISIT, 32'hA5A5_5A5A);   // no page: nothing pushed
    send_request(ACT_VISIT, 32'h5A5A_A5A5);
    send_request(ACT_CLEAR, 32'hFFFF_0000);
    stop_requests();
  endtask

  task automatic test_full_back_stack();
    logic [NODE_W-1:0] base;
    base = $urandom();
    send_request(ACT_CLEAR, base);
    for (int i = 0; i <= DEPTH; i++)
      send_request(ACT_VISIT, {base[NODE_W-1:8], 8'(i)});
    send_request(ACT_VISIT, ~base);           // back stack full: refused
    send_request(ACT_VISIT, cur_node);
    send_request(ACT_FORWARD, 32'h0);
    for (int i = 0; i <= DEPTH; i++)
      send_request(ACT_BACK, $urandom());     // last one runs out
    for (int i = 0; i <= DEPTH; i++)
      send_request(ACT_FORWARD, $urandom());
    send_request(ACT_BACK, 32'h0);
    send_request(ACT_VISIT, ~base);           // refills to the brim
    send_request(ACT_VISIT, base);
    stop_requests();
  endtask

  task automatic test_rsp_backpressure();
    req_steady    = 1'b1;
    stall_request = 300;
    for (int i = 0; i < 12; i++)
      send_request(pick_action(60, 25, 13), pick_node());
    req_steady = 1'b0;
    stop_requests();
  endtask

  task automatic test_random_navigation(int count);
    int stop_at;
    int run_len;
    int w_visit;
    int w_back;
    int w_fwd;
    stop_at = sent_cnt + count;
    while (sent_cnt < stop_at) begin
      run_len    = $urandom_range(20, 200);
      if (run_len > stop_at - sent_cnt) run_len = stop_at - sent_cnt;
      req_steady = ($urandom_range(0, 4) == 0);
      rsp_steady = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 3))
        0: begin w_visit = 75; w_back = 12; w_fwd = 12; end   // grow deep
        1: begin w_visit = 30; w_back = 35; w_fwd = 33; end   // wander
        2: begin w_visit = 50; w_back = 30; w_fwd = 15; end
        default: begin w_visit = 40; w_back = 25; w_fwd = 25; end
      endcase
      repeat (run_len) send_request(pick_action(w_visit, w_back, w_fwd), pick_node());
    end
    req_steady = 1'b0;
    rsp_steady = 1'b0;
    stop_requests();
  endtask

  initial begin
    rst_ni          = 1'b0;
    req_bus.valid   <= 1'b0;
    req_bus.action  <= ACT_VISIT;
    req_bus.node_id <= '0;
    back_cnt        = 0;
    fwd_cnt         = 0;
    cur_node        = NO_NODE;
    cur_live        = 1'b0;
    mismatch_cnt    = 0;
    sent_cnt        = 0;
    req_steady      = 1'b0;
    rsp_steady      = 1'b0;
    stall_request   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_basics();
    test_full_back_stack();
    test_rsp_backpressure();
    test_random_navigation(1700);

    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== back_forward_history_unit.f =====
+incdir+hdl
hdl/bfh_pkg.sv
hdl/bfh_req_if.sv
hdl/bfh_rsp_if.sv
hdl/bfh_datapath.sv
hdl/bfh_ctrl.sv
hdl/back_forward_history_unit.sv
dv/tb.sv
